// ===== rtl/ddm_pkg.sv =====
`default_nettype none
package ddm_pkg;

  // Default sizes handed down from the top level
  localparam int TRIG_ENTRIES_DEF = 1024;
  localparam int MAX_SIDE_DEF     = 1024;

  // Field widths
  localparam int XI_W   = 11;  // column, below the clamped map width
  localparam int YI_W   = 20;  // row
  localparam int HEAD_W = 9;
  localparam int SPD_W  = 15;
  localparam int IDX_W  = 12;  // sine table index, up to 4096 entries
  localparam int ANG_W  = 25;  // degrees Q16, below one full turn
  localparam int ND_W   = 38;  // scaled heading-change numerator

  // Angle and speed constants
  localparam logic [ANG_W-1:0] DEG_TURN_Q16    = 25'd23592960;
  localparam logic [ANG_W-1:0] DEG_QUARTER_Q16 = 25'd5898240;
  localparam logic [ANG_W-1:0] DEG_HALF_Q16    = 25'd11796480;
  localparam logic [25:0]      RAD2DEG_Q20     = 26'd60078979;
  localparam logic [SPD_W-1:0] SPEED_MIN       = 15'd6554;
  localparam logic [SPD_W-1:0] SPEED_MAX       = 15'd16384;

  // Division by 45 through a reciprocal: 372827 * 45 = 2^24 - 1
  localparam logic [18:0] RECIP_45 = 19'd372827;
  localparam logic [5:0]  DIV_45   = 6'd45;

  typedef enum logic [2:0] {
    REG_ACCEL, REG_AXLE, REG_TIME, REG_WIDTH, REG_HEIGHT
  } reg_idx_t;

  typedef enum logic [2:0] {
    PR_HARD_LEFT, PR_LEFT, PR_STRAIGHT, PR_RIGHT, PR_HARD_RIGHT
  } prim_t;

  typedef enum logic [1:0] {
    FR_IDLE, FR_DIV, FR_HOLD
  } front_state_t;

  // Pose after the front end has split the cell index
  typedef struct packed {
    logic [XI_W-1:0]   xi;
    logic [YI_W-1:0]   yi;
    logic [HEAD_W-1:0] head;
    logic [SPD_W-1:0]  ul;
    logic [SPD_W-1:0]  ur;
  } item_t;

  // One primitive in flight through the back end
  typedef struct packed {
    logic                     vld;
    prim_t                    prim;
    logic [SPD_W-1:0]         vl;
    logic [SPD_W-1:0]         vr;
    logic [15:0]              cost;
    logic [15:0]              vsum;
    logic [13:0]              absdv;
    logic                     neg;
    logic [XI_W-1:0]          xi;
    logic [YI_W-1:0]          yi;
    logic [HEAD_W-1:0]        head;
    logic [21:0]              p1;
    logic [15:0]              travel;
    logic [47:0]              p2;
    logic [ND_W-1:0]          nd;
    logic [ANG_W-1:0]         hmod;
    logic [15:0]              rem;
    logic [ANG_W-1:0]         qmod;
    logic [ANG_W-1:0]         ang;
    logic [ANG_W-1:0]         cang;
    logic [20:0]              ys;
    logic [20:0]              yc;
    logic [12:0]              es;
    logic [12:0]              ec;
    logic [IDX_W-1:0]         is;
    logic [IDX_W-1:0]         ic;
    logic signed [15:0]       sn;
    logic signed [15:0]       cs;
    logic signed [32:0]       ms;
    logic signed [32:0]       mc;
    logic signed [31:0]       xf;
    logic signed [39:0]       yf;
    logic                     ok;
    logic [37:0]              wy;
  } pipe_t;

  // Clamp a widened speed into the allowed band
  function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [17:0] v);
    logic [SPD_W-1:0] r;
    begin
      if (v > $signed({3'b000, SPEED_MAX})) r = SPEED_MAX;
      else if (v < $signed({3'b000, SPEED_MIN})) r = SPEED_MIN;
      else r = v[SPD_W-1:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ddm_fifo.sv =====
`default_nettype none
module ddm_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr,
  input  wire ddm_pkg::item_t wdata,
  output logic                full,
  input  wire logic           rd,
  output ddm_pkg::item_t      rdata,
  output logic                empty
);
  import ddm_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  // Advance pointers and count
  always_comb begin
    wp_nxt  = do_wr ? ~wp_r : wp_r;
    rp_nxt  = do_rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// ===== rtl/ddm_front.sv =====
`default_nettype none
module ddm_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [19:0]                   cell_index,
  input  wire logic [ddm_pkg::HEAD_W-1:0]    heading_deg,
  input  wire logic [ddm_pkg::SPD_W-1:0]     left_speed,
  input  wire logic [ddm_pkg::SPD_W-1:0]     right_speed,
  input  wire logic [ddm_pkg::XI_W-1:0]      wd,
  output logic                               q_push,
  output ddm_pkg::item_t                     q_item,
  input  wire logic                          q_full
);
  import ddm_pkg::*;

  localparam int BITS_PER_CYC = 4;
  localparam int ITERS = 20 / BITS_PER_CYC;

  front_state_t     state_r, state_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [19:0]      num_r, num_nxt;
  logic [XI_W-1:0]  rem_r, rem_nxt;
  logic [HEAD_W-1:0] head_r;
  logic [SPD_W-1:0] ul_r, ur_r;
  logic             accept;
  logic [19:0]      num_w;
  logic [XI_W:0]    rem_w;

  assign accept = push && !full;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: if (accept) state_nxt = FR_DIV;
      FR_DIV:  if (cnt_r == 3'(ITERS - 1)) state_nxt = FR_HOLD;
      FR_HOLD: if (!q_full) state_nxt = accept ? FR_DIV : FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    full   = 1'b0;
    q_push = 1'b0;
    case (state_r)
      FR_IDLE: full = 1'b0;
      FR_DIV:  full = 1'b1;
      FR_HOLD: begin
        full   = q_full;
        q_push = 1'b1;
      end
      default: full = 1'b1;
    endcase
  end

  assign q_item = '{xi: rem_r, yi: num_r, head: head_r, ul: ul_r, ur: ur_r};

  // Restoring divide, four quotient bits a cycle
  always_comb begin
    num_w = num_r;
    rem_w = {1'b0, rem_r};
    for (int b = 0; b < BITS_PER_CYC; b++) begin
      rem_w = {rem_w[XI_W-1:0], num_w[19]};
      num_w = {num_w[18:0], 1'b0};
      if (rem_w >= {1'b0, wd}) begin
        rem_w    = rem_w - {1'b0, wd};
        num_w[0] = 1'b1;
      end
    end
  end

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      num_nxt = cell_index;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (state_r == FR_DIV) begin
      num_nxt = num_w;
      rem_nxt = rem_w[XI_W-1:0];
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the pose while dividing
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (accept) begin
      head_r <= heading_deg;
      ul_r   <= left_speed;
      ur_r   <= right_speed;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ddm_back.sv =====
`default_nettype none
module ddm_back #(
  parameter int TRIG_ENTRIES = ddm_pkg::TRIG_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire ddm_pkg::item_t              q_item,
  output logic                             q_pop,
  input  wire logic [14:0]                 accel,
  input  wire logic [15:0]                 axle,
  input  wire logic [7:0]                  tt,
  input  wire logic [10:0]                 w,
  input  wire logic [10:0]                 h,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [2:0]                       primitive_res,
  output logic                             valid_res,
  output logic [19:0]                      next_cell,
  output logic [8:0]                       next_heading,
  output logic [15:0]                      travel,
  output logic [15:0]                      smooth_cost,
  output logic [14:0]                      new_left_speed,
  output logic [14:0]                      new_right_speed,
  output logic                             last
);
  import ddm_pkg::*;

  localparam int TW = $clog2(TRIG_ENTRIES);
  localparam logic [12:0] TRIG_N = 13'(TRIG_ENTRIES);
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  // Sine of r / 2^30 quarter turns, Q2.14
  function automatic logic signed [15:0] quarter_sin(input longint r);
    longint x, x2, t, s;
    begin
      x  = (r * HALF_PI_Q30) >>> 30;
      x2 = (x * x) >>> 30;
      t  = x;
      s  = x;
      t = ((t * x2) >>> 30) / 6;   s = s - t;
      t = ((t * x2) >>> 30) / 20;  s = s + t;
      t = ((t * x2) >>> 30) / 42;  s = s - t;
      t = ((t * x2) >>> 30) / 72;  s = s + t;
      t = ((t * x2) >>> 30) / 110; s = s - t;
      return 16'((s + 32768) >>> 16);
    end
  endfunction

  function automatic logic signed [15:0] sin_at(input int i);
    longint f, q, r;
    logic signed [15:0] v;
    begin
      f = (longint'(i) <<< 32) / TRIG_ENTRIES;
      q = (f >>> 30) & 3;
      r = f & 64'h3FFF_FFFF;
      if (q[0]) r = 64'h4000_0000 - r;
      v = quarter_sin(r);
      return (q >= 2) ? -v : v;
    end
  endfunction

  function automatic prim_t next_prim(input prim_t p);
    prim_t n;
    begin
      case (p)
        PR_HARD_LEFT:  n = PR_LEFT;
        PR_LEFT:       n = PR_STRAIGHT;
        PR_STRAIGHT:   n = PR_RIGHT;
        PR_RIGHT:      n = PR_HARD_RIGHT;
        default:       n = PR_HARD_LEFT;
      endcase
      return n;
    end
  endfunction

  // Sine table, built at elaboration
  logic signed [15:0] sin_tbl [TRIG_ENTRIES];
  for (genvar g = 0; g < TRIG_ENTRIES; g++) begin : g_sin
    assign sin_tbl[g] = sin_at(g);
  end

  prim_t  prim_r;
  logic   en, iss;
  pipe_t  s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  pipe_t  s4_r, s4_nxt, s5_r, s5_nxt, s6_r, s6_nxt, s7_r, s7_nxt;
  pipe_t  s8_r, s8_nxt, s9_r, s9_nxt, s10_r, s10_nxt, s11_r, s11_nxt;
  pipe_t  dv_in [ND_W];
  pipe_t  dv_nxt [ND_W];
  pipe_t  dv_r [ND_W];
  pipe_t  out_r;
  logic [19:0] cell_r, cell_nxt;

  // Advance the whole back end unless a result waits unclaimed
  assign en    = !out_r.vld || pop;
  assign iss   = en && !q_empty;
  assign q_pop = iss && (prim_r == PR_HARD_RIGHT);
  assign empty = !out_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) prim_r <= PR_HARD_LEFT;
    else if (iss) prim_r <= next_prim(prim_r);
  end

  // Issue: apply the speed change and clamp
  logic signed [17:0] vl_raw, vr_raw, a18;
  logic [SPD_W-1:0]   vl_c, vr_c;
  always_comb begin
    a18    = $signed({3'b000, accel});
    vl_raw = $signed({3'b000, q_item.ul});
    vr_raw = $signed({3'b000, q_item.ur});
    s0_nxt = '0;
    case (prim_r)
      PR_HARD_LEFT: begin
        vl_raw = vl_raw - a18;
        vr_raw = vr_raw + a18;
        s0_nxt.cost = {accel, 1'b0};
      end
      PR_LEFT: begin
        vr_raw = vr_raw + a18;
        s0_nxt.cost = {1'b0, accel};
      end
      PR_STRAIGHT: s0_nxt.cost = '0;
      PR_RIGHT: begin
        vl_raw = vl_raw + a18;
        s0_nxt.cost = {1'b0, accel};
      end
      default: begin
        vl_raw = vl_raw + a18;
        vr_raw = vr_raw - a18;
        s0_nxt.cost = {accel, 1'b0};
      end
    endcase
    vl_c         = clamp_speed(vl_raw);
    vr_c         = clamp_speed(vr_raw);
    s0_nxt.vld   = iss;
    s0_nxt.prim  = prim_r;
    s0_nxt.vl    = vl_c;
    s0_nxt.vr    = vr_c;
    s0_nxt.vsum  = {1'b0, vl_c} + {1'b0, vr_c};
    s0_nxt.neg   = vl_c < vr_c;
    s0_nxt.absdv = (vl_c < vr_c) ? 14'(vr_c - vl_c) : 14'(vl_c - vr_c);
    s0_nxt.xi    = q_item.xi;
    s0_nxt.yi    = q_item.yi;
    s0_nxt.head  = q_item.head;
  end

  // Scale by step time
  logic [23:0] trav_w;
  always_comb begin
    s1_nxt        = s0_r;
    s1_nxt.p1     = {8'd0, s0_r.absdv} * {14'd0, tt};
    trav_w        = {8'd0, s0_r.vsum} * {16'd0, tt} + 24'd64;
    s1_nxt.travel = trav_w[22:7];
  end

  // Radians to degrees
  always_comb begin
    s2_nxt    = s1_r;
    s2_nxt.p2 = {26'd0, s1_r.p1} * {22'd0, RAD2DEG_Q20};
  end

  // Round against the axle and fold the start heading into one turn
  logic [47:0]      ndsum;
  logic [ANG_W-1:0] h65;
  always_comb begin
    s3_nxt      = s2_r;
    ndsum       = s2_r.p2 + {23'd0, axle, 9'd0};
    s3_nxt.nd   = ndsum[47:10];
    h65         = {s2_r.head, 16'd0};
    s3_nxt.hmod = (h65 >= DEG_TURN_Q16) ? h65 - DEG_TURN_Q16 : h65;
    s3_nxt.rem  = '0;
    s3_nxt.qmod = '0;
  end

  // Divide by the axle one bit a stage, keeping the quotient modulo one turn
  for (genvar j = 0; j < ND_W; j++) begin : g_div
    logic [16:0]      rem2;
    logic             ge;
    logic [ANG_W:0]   q2;
    if (j == 0) begin : g_first
      assign dv_in[j] = s3_r;
    end else begin : g_rest
      assign dv_in[j] = dv_r[j-1];
    end
    always_comb begin
      rem2 = {dv_in[j].rem, dv_in[j].nd[ND_W-1-j]};
      ge   = rem2 >= {1'b0, axle};
      q2   = {dv_in[j].qmod, ge};
      dv_nxt[j]      = dv_in[j];
      dv_nxt[j].rem  = ge ? 16'(rem2 - {1'b0, axle}) : rem2[15:0];
      dv_nxt[j].qmod = (q2 >= {1'b0, DEG_TURN_Q16}) ?
                       ANG_W'(q2 - {1'b0, DEG_TURN_Q16}) : q2[ANG_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j].vld <= 1'b0;
      else if (en) dv_r[j] <= dv_nxt[j];
    end
  end

  // New heading and the cosine angle
  logic signed [ANG_W+1:0] adiff;
  logic [ANG_W:0]          asum, csum;
  always_comb begin
    s4_nxt = dv_r[ND_W-1];
    adiff  = $signed({2'b00, dv_r[ND_W-1].hmod}) - $signed({2'b00, dv_r[ND_W-1].qmod});
    asum   = {1'b0, dv_r[ND_W-1].hmod} + {1'b0, dv_r[ND_W-1].qmod};
    if (dv_r[ND_W-1].neg) begin
      s4_nxt.ang = (adiff < 0) ? ANG_W'(adiff + $signed({2'b00, DEG_TURN_Q16}))
                               : adiff[ANG_W-1:0];
    end else begin
      s4_nxt.ang = (asum >= {1'b0, DEG_TURN_Q16}) ?
                   ANG_W'(asum - {1'b0, DEG_TURN_Q16}) : asum[ANG_W-1:0];
    end
    csum        = {1'b0, s4_nxt.ang} + {1'b0, DEG_QUARTER_Q16};
    s4_nxt.cang = (csum >= {1'b0, DEG_TURN_Q16}) ?
                  ANG_W'(csum - {1'b0, DEG_TURN_Q16}) : csum[ANG_W-1:0];
  end

  // Scale the angles to table steps, in units of 1/360
  logic [37:0] ps, pc;
  always_comb begin
    s5_nxt    = s4_r;
    ps        = {13'd0, s4_r.ang} * {25'd0, TRIG_N} + {13'd0, DEG_HALF_Q16};
    pc        = {13'd0, s4_r.cang} * {25'd0, TRIG_N} + {13'd0, DEG_HALF_Q16};
    s5_nxt.ys = ps[36:16];
    s5_nxt.yc = pc[36:16];
  end

  // Estimate the quotient by 360 through the reciprocal of 45
  logic [36:0] es_p, ec_p;
  always_comb begin
    s6_nxt    = s5_r;
    es_p      = {19'd0, s5_r.ys[20:3]} * {18'd0, RECIP_45};
    ec_p      = {19'd0, s5_r.yc[20:3]} * {18'd0, RECIP_45};
    s6_nxt.es = es_p[36:24];
    s6_nxt.ec = ec_p[36:24];
  end

  // Correct the estimate and wrap to the table
  logic [18:0] rs, rc;
  logic [12:0] ks, kc;
  always_comb begin
    s7_nxt = s6_r;
    rs = {1'b0, s6_r.ys[20:3]} - {6'd0, s6_r.es} * {13'd0, DIV_45};
    rc = {1'b0, s6_r.yc[20:3]} - {6'd0, s6_r.ec} * {13'd0, DIV_45};
    ks = (rs >= {13'd0, DIV_45}) ? s6_r.es + 13'd1 : s6_r.es;
    kc = (rc >= {13'd0, DIV_45}) ? s6_r.ec + 13'd1 : s6_r.ec;
    s7_nxt.is = (ks >= TRIG_N) ? IDX_W'(ks - TRIG_N) : ks[IDX_W-1:0];
    s7_nxt.ic = (kc >= TRIG_N) ? IDX_W'(kc - TRIG_N) : kc[IDX_W-1:0];
  end

  // Table read
  always_comb begin
    s8_nxt    = s7_r;
    s8_nxt.sn = sin_tbl[s7_r.is[TW-1:0]];
    s8_nxt.cs = sin_tbl[s7_r.ic[TW-1:0]];
  end

  // Speed sum times sine and cosine
  always_comb begin
    s9_nxt    = s8_r;
    s9_nxt.ms = $signed({1'b0, s8_r.vsum}) * s8_r.sn;
    s9_nxt.mc = $signed({1'b0, s8_r.vsum}) * s8_r.cs;
  end

  // Times step time, floor to Q16, add the start cell
  logic signed [41:0] mt_s, mt_c;
  always_comb begin
    s10_nxt    = s9_r;
    mt_s       = s9_r.ms * $signed({1'b0, tt});
    mt_c       = s9_r.mc * $signed({1'b0, tt});
    s10_nxt.xf = $signed({5'd0, s9_r.xi, 16'd0}) + 32'(mt_c >>> 13);
    s10_nxt.yf = $signed({4'd0, s9_r.yi, 16'd0}) + 40'(mt_s >>> 13);
  end

  // Bounds check and row offset
  always_comb begin
    s11_nxt    = s10_r;
    s11_nxt.ok = !s10_r.xf[31] && (s10_r.xf < $signed({5'd0, w, 16'd0})) &&
                 !s10_r.yf[39] && (s10_r.yf < $signed({13'd0, h, 16'd0}));
    s11_nxt.wy = {27'd0, w} * {11'd0, s10_r.yf[26:0]};
  end

  logic [38:0] csum_w;
  always_comb begin
    csum_w   = {1'b0, s11_r.wy} + {12'd0, s11_r.xf[26:0]};
    cell_nxt = s11_r.ok ? csum_w[35:16] : 20'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld  <= 1'b0;
      s1_r.vld  <= 1'b0;
      s2_r.vld  <= 1'b0;
      s3_r.vld  <= 1'b0;
      s4_r.vld  <= 1'b0;
      s5_r.vld  <= 1'b0;
      s6_r.vld  <= 1'b0;
      s7_r.vld  <= 1'b0;
      s8_r.vld  <= 1'b0;
      s9_r.vld  <= 1'b0;
      s10_r.vld <= 1'b0;
      s11_r.vld <= 1'b0;
      out_r.vld <= 1'b0;
    end else if (en) begin
      s0_r   <= s0_nxt;
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      s4_r   <= s4_nxt;
      s5_r   <= s5_nxt;
      s6_r   <= s6_nxt;
      s7_r   <= s7_nxt;
      s8_r   <= s8_nxt;
      s9_r   <= s9_nxt;
      s10_r  <= s10_nxt;
      s11_r  <= s11_nxt;
      out_r  <= s11_r;
      cell_r <= cell_nxt;
    end
  end

  // Result beat
  assign primitive_res   = out_r.prim;
  assign valid_res       = out_r.ok;
  assign next_cell       = cell_r;
  assign next_heading    = out_r.ang[ANG_W-1:16];
  assign travel          = out_r.travel;
  assign smooth_cost     = out_r.cost;
  assign new_left_speed  = out_r.vl;
  assign new_right_speed = out_r.vr;
  assign last            = (out_r.prim == PR_HARD_RIGHT);

endmodule
`default_nettype wire

// ===== rtl/diff_drive_motion_primitives.sv =====
`default_nettype none
// Channel   Handshake                 Payload
// input     push / full               in_cell_index, in_heading_deg, in_*_speed
// result    empty / pop               out_primitive_res .. out_last (5 beats/item)
// config    cfg_we                    cfg_idx, cfg_data
//
// The front end sets the pose rate: a 4-bit-a-cycle divider splits the cell
// index, then a hand-off into the queue; no new pose is taken while dividing.
// The back end issues one primitive a cycle, five per pose, while a pose waits
// in the queue and no result is unclaimed; it has a 38-stage axle divider.
// Reset is synchronous and clears only control state; no clearing pass.
// A result left unpopped freezes the back end; the front keeps taking poses
// until its two-entry queue fills.
module diff_drive_motion_primitives #(
  parameter int TRIG_ENTRIES = ddm_pkg::TRIG_ENTRIES_DEF,
  parameter int MAX_SIDE     = ddm_pkg::MAX_SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [19:0] in_cell_index,
  input  wire logic [8:0]  in_heading_deg,
  input  wire logic [14:0] in_left_speed,
  input  wire logic [14:0] in_right_speed,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_primitive_res,
  output logic             out_valid_res,
  output logic [19:0]      out_next_cell,
  output logic [8:0]       out_next_heading,
  output logic [15:0]      out_travel,
  output logic [15:0]      out_smooth_cost,
  output logic [14:0]      out_new_left_speed,
  output logic [14:0]      out_new_right_speed,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_data
);
  import ddm_pkg::*;

  localparam logic [12:0] SIDE_MAX = 13'(MAX_SIDE);

  logic [14:0] accel_r;
  logic [15:0] axle_r;
  logic [7:0]  time_r;
  logic [10:0] width_r, height_r;
  logic [10:0] w_eff, h_eff, wd;
  logic [15:0] axle_eff;
  logic        q_push, q_full, q_pop, q_empty;
  item_t       f_item, q_item;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r  <= 15'd1638;
      axle_r   <= 16'd256;
      time_r   <= 8'd1;
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_ACCEL:  accel_r  <= cfg_data[14:0];
        REG_AXLE:   axle_r   <= cfg_data;
        REG_TIME:   time_r   <= cfg_data[7:0];
        REG_WIDTH:  width_r  <= cfg_data[10:0];
        REG_HEIGHT: height_r <= cfg_data[10:0];
        default:    ;
      endcase
    end
  end

  // Clamp map sides, keep divisors nonzero
  assign w_eff    = ({2'b00, width_r} > SIDE_MAX) ? 11'(SIDE_MAX) : width_r;
  assign h_eff    = ({2'b00, height_r} > SIDE_MAX) ? 11'(SIDE_MAX) : height_r;
  assign wd       = (w_eff == 11'd0) ? 11'd1 : w_eff;
  assign axle_eff = (axle_r == 16'd0) ? 16'd1 : axle_r;

  ddm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .cell_index  (in_cell_index),
    .heading_deg (in_heading_deg),
    .left_speed  (in_left_speed),
    .right_speed (in_right_speed),
    .wd          (wd),
    .q_push      (q_push),
    .q_item      (f_item),
    .q_full      (q_full)
  );

  ddm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .wdata (f_item),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  ddm_back #(
    .TRIG_ENTRIES (TRIG_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .accel           (accel_r),
    .axle            (axle_eff),
    .tt              (time_r),
    .w               (w_eff),
    .h               (h_eff),
    .pop             (pop),
    .empty           (empty),
    .primitive_res   (out_primitive_res),
    .valid_res       (out_valid_res),
    .next_cell       (out_next_cell),
    .next_heading    (out_next_heading),
    .travel          (out_travel),
    .smooth_cost     (out_smooth_cost),
    .new_left_speed  (out_new_left_speed),
    .new_right_speed (out_new_right_speed),
    .last            (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_diff_drive_motion_primitives.sv =====
`default_nettype none
module tb_diff_drive_motion_primitives;
  timeunit 1ns;
  timeprecision 1ps;
  import ddm_pkg::*;

  localparam int      TRIG_N      = 1024;
  localparam int      SIDE_MAX    = 1024;
  localparam longint  TURN_Q16    = 64'd23592960;
  localparam longint  QUARTER_Q16 = 64'd5898240;
  localparam longint  R2D_Q20     = 64'd60078979;
  localparam longint  HALF_PI_Q30 = 64'd1686629713;
  localparam int      LATENCY     = 120;
  localparam longint  CYCLE_LIMIT = 64'd1500000;

  typedef struct {
    logic [2:0]  prim;
    logic        ok;
    logic [19:0] cell_no;
    logic [8:0]  heading;
    logic [15:0] travel;
    logic [15:0] cost;
    logic [14:0] vl;
    logic [14:0] vr;
    logic        last;
  } motion_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [19:0] in_cell_index = '0;
  logic [8:0]  in_heading_deg = '0;
  logic [14:0] in_left_speed = '0;
  logic [14:0] in_right_speed = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_primitive_res;
  logic        out_valid_res;
  logic [19:0] out_next_cell;
  logic [8:0]  out_next_heading;
  logic [15:0] out_travel;
  logic [15:0] out_smooth_cost;
  logic [14:0] out_new_left_speed;
  logic [14:0] out_new_right_speed;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  diff_drive_motion_primitives u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_cell_index(in_cell_index), .in_heading_deg(in_heading_deg),
    .in_left_speed(in_left_speed), .in_right_speed(in_right_speed),
    .empty(empty), .pop(pop),
    .out_primitive_res(out_primitive_res), .out_valid_res(out_valid_res),
    .out_next_cell(out_next_cell), .out_next_heading(out_next_heading),
    .out_travel(out_travel), .out_smooth_cost(out_smooth_cost),
    .out_new_left_speed(out_new_left_speed), .out_new_right_speed(out_new_right_speed),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers and the sine table
  longint  accel_q, axle_q, step_q, width_q, height_q;
  longint  sine_tab [TRIG_N];
  motion_t expected_q [$];
  int      errors = 0;
  longint  cycles = 0;
  int      send_idle_pct = 0;
  int      pop_idle_pct = 0;

  function automatic longint quarter_sine(longint unsigned r);
    longint x, x2, t, s;
    x = longint'((r * HALF_PI_Q30) >> 30);
    x2 = (x * x) >>> 30;
    t = x; s = x;
    t = ((t * x2) >>> 30) / 6;   s -= t;
    t = ((t * x2) >>> 30) / 20;  s += t;
    t = ((t * x2) >>> 30) / 42;  s -= t;
    t = ((t * x2) >>> 30) / 72;  s += t;
    t = ((t * x2) >>> 30) / 110; s -= t;
    return (s + 32768) >>> 16;
  endfunction

  task automatic build_sine_table();
    longint unsigned f, q, r;
    longint v;
    for (int i = 0; i < TRIG_N; i++) begin
      f = (longint'(i) << 32) / TRIG_N;
      q = (f >> 30) & 3;
      r = f & 64'h3FFF_FFFF;
      if (q[0]) r = 64'h4000_0000 - r;
      v = quarter_sine(r);
      sine_tab[i] = (q >= 2) ? -v : v;
    end
  endtask

  function automatic longint sine_at(longint ang);
    longint k;
    k = (ang * TRIG_N + TURN_Q16 / 2) / TURN_Q16;
    return sine_tab[k % TRIG_N];
  endfunction

  function automatic longint floor_8192(longint v);
    if (v >= 0) return v >>> 13;
    return -(((-v) + 8191) >>> 13);
  endfunction

  function automatic longint clamp_v(longint v);
    if (v > 16384) return 16384;
    if (v < 6554) return 6554;
    return v;
  endfunction

  // Expand one pose into its five motion primitives
  task automatic predict_primitives(logic [19:0] idx, logic [8:0] head,
                                    logic [14:0] ul, logic [14:0] ur);
    longint w, h, wd, axle, xi, yi, dl, dr, vl, vr, dv, mag, ang, vsum, xf, yf;
    int     dir_l [5];
    int     dir_r [5];
    motion_t m;
    dir_l = '{-1, 0, 0, 1, 1};
    dir_r = '{1, 1, 0, 0, -1};
    w = width_q > SIDE_MAX ? SIDE_MAX : width_q;
    h = height_q > SIDE_MAX ? SIDE_MAX : height_q;
    wd = w ? w : 1;
    axle = axle_q ? axle_q : 1;
    xi = longint'(idx) % wd;
    yi = longint'(idx) / wd;
    for (int k = 0; k < 5; k++) begin
      dl = dir_l[k] * accel_q;
      dr = dir_r[k] * accel_q;
      vl = clamp_v(longint'(ul) + dl);
      vr = clamp_v(longint'(ur) + dr);
      vsum = vl + vr;
      dv = vl - vr;
      mag = ((dv < 0 ? -dv : dv) * step_q * R2D_Q20 + axle * 512) / (axle * 1024);
      ang = (longint'(head) * 65536 + (dv < 0 ? -mag : mag)) % TURN_Q16;
      if (ang < 0) ang += TURN_Q16;
      xf = xi * 65536 + floor_8192(vsum * sine_at((ang + QUARTER_Q16) % TURN_Q16) * step_q);
      yf = yi * 65536 + floor_8192(vsum * sine_at(ang) * step_q);
      m.prim = k[2:0];
      m.ok = xf >= 0 && xf < w * 65536 && yf >= 0 && yf < h * 65536;
      m.cell_no = m.ok ? 20'((w * yf + xf) >>> 16) : 20'd0;
      m.heading = 9'(ang >>> 16);
      m.travel = 16'((vsum * step_q + 64) >>> 7);
      m.cost = 16'((dl < 0 ? -dl : dl) + (dr < 0 ? -dr : dr));
      m.vl = 15'(vl);
      m.vr = 15'(vr);
      m.last = (k == 4);
      expected_q = {expected_q, m};
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_diff_drive_motion_primitives: FAIL");
      $finish;
    end
  end

  // Drive pop with random stalls
  always @(negedge clk) begin
    if (rst_n) pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    motion_t m;
    if (rst_n && pop && !empty) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_primitive_res, -1);
      end else begin
        m = expected_q.pop_front();
        if (out_primitive_res !== m.prim) report_mismatch("primitive", out_primitive_res, m.prim);
        if (out_valid_res !== m.ok) report_mismatch("valid", out_valid_res, m.ok);
        if (out_next_cell !== m.cell_no) report_mismatch("next_cell", out_next_cell, m.cell_no);
        if (out_next_heading !== m.heading)
          report_mismatch("next_heading", out_next_heading, m.heading);
        if (out_travel !== m.travel) report_mismatch("travel", out_travel, m.travel);
        if (out_smooth_cost !== m.cost) report_mismatch("smooth_cost", out_smooth_cost, m.cost);
        if (out_new_left_speed !== m.vl) report_mismatch("left_speed", out_new_left_speed, m.vl);
        if (out_new_right_speed !== m.vr)
          report_mismatch("right_speed", out_new_right_speed, m.vr);
        if (out_last !== m.last) report_mismatch("last", out_last, m.last);
      end
    end
  end

  // Send one pose; hold push until the beat is taken
  task automatic send_pose(logic [19:0] idx, logic [8:0] head,
                           logic [14:0] ul, logic [14:0] ur);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_cell_index <= idx;
    in_heading_deg <= head;
    in_left_speed <= ul;
    in_right_speed <= ur;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_primitives(idx, head, ul, ur);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    case (idx)
      REG_ACCEL:  accel_q = value & 16'h7FFF;
      REG_AXLE:   axle_q = value;
      REG_TIME:   step_q = value & 16'hFF;
      REG_WIDTH:  width_q = value & 16'h7FF;
      REG_HEIGHT: height_q = value & 16'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] a, logic [15:0] ax, logic [15:0] t,
                          logic [15:0] w, logic [15:0] h);
    write_reg(REG_ACCEL, a);
    write_reg(REG_AXLE, ax);
    write_reg(REG_TIME, t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // Field extremes and the named corner cases
  task automatic test_directed();
    send_pose(20'd0, 9'd0, 15'd0, 15'd0);
    send_pose(20'hFFFFF, 9'h1FF, 15'h7FFF, 15'h7FFF);
    send_pose(20'd524800, 9'd359, 15'd16384, 15'd6554);
    send_pose(20'd1023, 9'd90, 15'd6554, 15'd16384);
    send_pose(20'd1047552, 9'd180, 15'd10000, 15'd10000);
    send_pose(20'd5, 9'd270, 15'd12000, 15'd8000);
    send_pose(20'h55555, 9'h0AA, 15'h2AAA, 15'h5555);
    wait_drained();
    // zero axle, long step, small map
    set_regs(16'd16384, 16'd0, 16'd255, 16'd16, 16'd8);
    send_pose(20'd0, 9'd45, 15'd8000, 15'd9000);
    send_pose(20'd127, 9'd300, 15'd16384, 15'd16384);
    send_pose(20'd200, 9'd10, 15'd0, 15'd32767);
    wait_drained();
    // zero map size and zero step
    set_regs(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_pose(20'd3, 9'd0, 15'd10000, 15'd12000);
    send_pose(20'd77, 9'd359, 15'd7000, 15'd16000);
    wait_drained();
    // oversized map and oversized accel
    set_regs(16'h7FFF, 16'd1, 16'd1, 16'h7FF, 16'h7FF);
    send_pose(20'd1048575, 9'd200, 15'd9000, 15'd9000);
    send_pose(20'd0, 9'd0, 15'd16384, 15'd6554);
    wait_drained();
  endtask

  task automatic random_regs();
    case ($urandom_range(2))
      0: set_regs(16'($urandom_range(16384)), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 255)), 16'($urandom_range(1, 1024)),
                  16'($urandom_range(1, 1024)));
      1: set_regs(16'($urandom_range(3000)), 16'($urandom_range(128, 1024)),
                  16'($urandom_range(1, 4)), 16'($urandom_range(64, 1024)),
                  16'($urandom_range(64, 1024)));
      default: set_regs(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
    endcase
  endtask

  // Random poses, mostly inside the map with speeds near the band
  task automatic test_random(int n);
    longint w, h;
    logic [19:0] idx;
    for (int i = 0; i < n; i++) begin
      w = width_q == 0 ? 1 : (width_q > SIDE_MAX ? SIDE_MAX : width_q);
      h = height_q > SIDE_MAX ? SIDE_MAX : (height_q == 0 ? 1 : height_q);
      if ($urandom_range(9) < 8) idx = 20'($urandom_range(0, int'(w * h - 1)));
      else idx = 20'($urandom);
      if ($urandom_range(9) < 8)
        send_pose(idx, 9'($urandom_range(359)), 15'($urandom_range(5000, 18000)),
                  15'($urandom_range(5000, 18000)));
      else
        send_pose(idx, 9'($urandom), 15'($urandom), 15'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_idle_phase(int snd, int rcv, int n);
    send_idle_pct = snd;
    pop_idle_pct = rcv;
    random_regs();
    test_random(n);
  endtask

  initial begin
    accel_q = 1638; axle_q = 256; step_q = 1; width_q = 1024; height_q = 1024;
    build_sine_table();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 6;
    pop_idle_pct = 54;
    test_directed();
    test_idle_phase(6, 54, 65);
    test_idle_phase(6, 54, 65);
    test_idle_phase(54, 6, 65);
    test_idle_phase(54, 6, 65);
    test_idle_phase(0, 0, 65);
    set_regs(16'd1638, 16'd256, 16'd1, 16'd1024, 16'd1024);
    test_random(65);
    if (errors == 0) $display("tb_diff_drive_motion_primitives: PASS");
    else $display("tb_diff_drive_motion_primitives: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
